// ===== design/scba_pkg.sv =====
package scba_pkg;
  localparam int GRANULE_BITS_D = 3;
  localparam int PAGE_BYTES_D   = 4096;
  localparam int SMALL_LIMIT_D  = 128;
  localparam int CLASS_COUNT_D  = 17;
  localparam int PAGE_COUNT_D   = 16;

  localparam int ADDR_W = 16;
  localparam int LINK_W = 14;
  localparam int IDX_W  = 13;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_LARGE = 2'd1,
    ST_OOM   = 2'd2
  } status_t;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;
endpackage

// ===== design/scba_if.sv =====
interface scba_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] req_size;
  logic [15:0] block_address;
  modport source (output valid, req_type, req_size, block_address, input ready);
  modport sink   (input valid, req_type, req_size, block_address, output ready);
endinterface

interface scba_rsp_if;
  logic                 valid;
  logic                 ready;
  logic [15:0]          result_address;
  scba_pkg::status_t    status;
  modport source (output valid, result_address, status, input ready);
  modport sink   (input valid, result_address, status, output ready);
endinterface

// ===== design/scba_ram.sv =====
module scba_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/size_class_block_allocator.sv =====
// channel | dir | handshake   | payload
// in_req  | in  | valid/ready | req_type, req_size, block_address
// out_rsp | out | valid/ready | result_address, status
// Items are handled one at a time. Large, free or bump items go from S_DEC to S_OUT;
// a pop also passes S_LINK and S_POP (head read, link read, write back). A page change
// carves the old page's tail into blocks of the smaller classes, largest first.
// Reset clears class heads (valid bits in flops); the link memory needs no clear.
// A waiting result sits in the output register; the next item is taken and worked
// on, and stalls in S_OUT until the output register is free.
module size_class_block_allocator #(
  parameter int GRANULE_BITS = scba_pkg::GRANULE_BITS_D,
  parameter int PAGE_BYTES   = scba_pkg::PAGE_BYTES_D,
  parameter int SMALL_LIMIT  = scba_pkg::SMALL_LIMIT_D,
  parameter int CLASS_COUNT  = scba_pkg::CLASS_COUNT_D,
  parameter int PAGE_COUNT   = scba_pkg::PAGE_COUNT_D
) (
  input logic        clk,
  input logic        rst_n,
  scba_req_if.sink   in_req,
  scba_rsp_if.source out_rsp
);
  localparam int LDEPTH  = 65536 >> GRANULE_BITS;
  localparam int LA_W    = $clog2(LDEPTH);
  localparam int CL_W    = $clog2(CLASS_COUNT);
  localparam int PC_W    = $clog2(PAGE_BYTES + 1);
  localparam int PI_W    = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int SZ_W    = 17;
  localparam int IDX_W_L = scba_pkg::IDX_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DEC   = 6'b000010,
    S_LINK  = 6'b000100,
    S_POP   = 6'b001000,
    S_CARVE = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic              typ_r;
  logic [15:0]       size_r;
  logic [15:0]       baddr_r;
  logic [CL_W-1:0]   cls_r;
  logic [CL_W-1:0]   s_r;
  logic [PC_W-1:0]   cursor_r;
  logic [PI_W-1:0]   page_r;
  logic [LA_W-1:0]   popg_r;

  logic [CLASS_COUNT-1:0] hvalid_r;
  logic [IDX_W_L-1:0]     hidx_r [CLASS_COUNT];

  logic              ovalid_r;
  logic [15:0]       oaddr_r;
  scba_pkg::status_t ostat_r;
  logic [15:0]       res_addr_r;
  scba_pkg::status_t res_stat_r;

  logic              we;
  logic [LA_W-1:0]   waddr, raddr;
  logic [scba_pkg::LINK_W-1:0] wdata, rdata;

  scba_ram #(.WIDTH(scba_pkg::LINK_W), .DEPTH(LDEPTH)) u_link (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [SZ_W-1:0] rnd;
  logic [SZ_W-1:0] cls_full;
  logic            oversize;
  assign rnd      = {1'b0, size_r} + SZ_W'((1 << GRANULE_BITS) - 1);
  assign cls_full = (rnd >> GRANULE_BITS) == '0 ? SZ_W'(1) : (rnd >> GRANULE_BITS);
  assign oversize = ({1'b0, size_r} > SZ_W'(SMALL_LIMIT)) ||
                    (cls_full >= SZ_W'(CLASS_COUNT));

  logic [CL_W-1:0] cls_d, cls_sel;
  assign cls_d   = CL_W'(cls_full);
  assign cls_sel = (state_r == S_DEC) ? cls_d : cls_r;

  logic [PC_W:0]   need_c, need_s;
  logic            fit_c, fit_s;
  logic [15:0]     bump_addr;
  assign need_c = (PC_W+1)'(cls_sel) << GRANULE_BITS;
  assign need_s = (PC_W+1)'(s_r) << GRANULE_BITS;
  assign fit_c  = need_c <= (PC_W+1)'(PAGE_BYTES) - {1'b0, cursor_r};
  assign fit_s  = need_s <= (PC_W+1)'(PAGE_BYTES) - {1'b0, cursor_r};
  assign bump_addr = 16'(32'(page_r) * PAGE_BYTES + 32'(cursor_r));

  logic bump_ok;
  assign bump_ok = !oversize && typ_r == scba_pkg::REQ_ALLOC && !hvalid_r[cls_sel] && fit_c;

  logic free_ok;
  assign free_ok = out_rsp.ready || !ovalid_r;
  assign in_req.ready   = (state_r == S_IDLE);
  assign out_rsp.valid  = ovalid_r;
  assign out_rsp.result_address = oaddr_r;
  assign out_rsp.status = ostat_r;

  logic [LA_W-1:0] baddr_g, bump_g;
  assign baddr_g = baddr_r[15:GRANULE_BITS];
  assign bump_g  = bump_addr[15:GRANULE_BITS];

  always_comb begin
    state_nxt = state_r;
    we    = 1'b0;
    waddr = baddr_g;
    wdata = {hvalid_r[cls_sel], hidx_r[cls_sel]};
    raddr = hidx_r[cls_sel][LA_W-1:0];
    unique case (state_r)
      S_IDLE:  if (in_req.valid) state_nxt = S_DEC;
      S_DEC: begin
        if (!oversize && typ_r == scba_pkg::REQ_FREE) we = 1'b1;
        if (oversize || typ_r == scba_pkg::REQ_FREE) state_nxt = S_OUT;
        else if (hvalid_r[cls_sel]) state_nxt = S_LINK;
        else if (fit_c) state_nxt = S_OUT;
        else state_nxt = S_CARVE;
      end
      S_LINK:  state_nxt = S_POP;
      S_POP:   state_nxt = S_OUT;
      S_CARVE: begin
        if (s_r != '0 && fit_s) begin
          we    = 1'b1;
          waddr = bump_g;
          wdata = {hvalid_r[s_r], hidx_r[s_r]};
        end
        if (s_r == '0) state_nxt = S_OUT;
      end
      S_OUT:   if (free_ok) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      hvalid_r <= '0;
      cursor_r <= '0;
      page_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_OUT && free_ok) ovalid_r <= 1'b1;
      else if (out_rsp.ready) ovalid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_req.valid) begin
          typ_r   <= in_req.req_type;
          size_r  <= in_req.req_size;
          baddr_r <= in_req.block_address;
        end
        S_DEC: begin
          cls_r      <= cls_d;
          s_r        <= CL_W'(cls_full - SZ_W'(1));
          res_addr_r <= bump_ok ? bump_addr : 16'h0000;
          res_stat_r <= oversize ? scba_pkg::ST_LARGE : scba_pkg::ST_OK;
          if (!oversize && typ_r == scba_pkg::REQ_FREE) begin
            hvalid_r[cls_d] <= 1'b1;
            hidx_r[cls_d]   <= IDX_W_L'(baddr_g);
          end
          if (bump_ok) cursor_r <= cursor_r + need_c[PC_W-1:0];
        end
        S_LINK: popg_r <= hidx_r[cls_r][LA_W-1:0];
        S_POP: begin
          hvalid_r[cls_r] <= rdata[scba_pkg::LINK_W-1];
          hidx_r[cls_r]   <= rdata[IDX_W_L-1:0];
          res_addr_r <= 16'({popg_r, GRANULE_BITS'(0)});
        end
        S_CARVE: begin
          if (s_r != '0) begin
            if (fit_s) begin
              hvalid_r[s_r] <= 1'b1;
              hidx_r[s_r]   <= IDX_W_L'(bump_g);
              cursor_r      <= cursor_r + need_s[PC_W-1:0];
            end else s_r <= s_r - CL_W'(1);
          end else begin
            if (32'(page_r) + 1 < PAGE_COUNT &&
                need_c <= (PC_W+1)'(PAGE_BYTES)) begin
              page_r     <= page_r + PI_W'(1);
              cursor_r   <= need_c[PC_W-1:0];
              res_addr_r <= 16'((32'(page_r) + 1) * PAGE_BYTES);
            end else begin
              if (32'(page_r) + 1 < PAGE_COUNT) begin
                page_r   <= page_r + PI_W'(1);
                cursor_r <= '0;
              end
              res_stat_r <= scba_pkg::ST_OOM;
            end
          end
        end
        S_OUT: if (free_ok) begin
          oaddr_r <= res_addr_r;
          ostat_r <= res_stat_r;
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== tb/sv/size_class_block_allocator_tb.sv =====
`timescale 1ns / 100ps

module size_class_block_allocator_tb;
  import scba_pkg::*;

  localparam int GB        = GRANULE_BITS_D;
  localparam int LINK_N    = 65536 >> GB;
  localparam int IDLE_MAX  = 5000;
  localparam int HOLD_LEN  = 300;
  localparam int N_RANDOM  = 900;
  localparam int N_FILL    = 500;

  typedef struct packed {
    logic [15:0] addr;
    status_t     status;
  } alloc_rsp_t;

  typedef struct {
    logic        kind;
    logic [15:0] size;
    logic [15:0] baddr;
    bit          typed;
    logic [15:0] exp_addr;
    status_t     exp_status;
  } stim_row_t;

  typedef struct {
    logic [15:0] addr;
    logic [15:0] size;
  } live_blk_t;

  logic clk;
  logic rst_n;

  scba_req_if req_if ();
  scba_rsp_if rsp_if ();

  size_class_block_allocator u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_if.sink),
    .out_rsp(rsp_if.source)
  );

  logic [LINK_W-1:0] class_head [CLASS_COUNT_D];
  logic [LINK_W-1:0] next_link [LINK_N];
  int unsigned       cur_page;
  int unsigned       cur_off;

  alloc_rsp_t rsp_q [$];
  live_blk_t  live_q [$];
  int         err_cnt;
  int         idle_cnt;
  bit         hold_req;
  bit         stim_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report(string what, logic [15:0] got_a, logic [15:0] exp_a,
                        int got_s, int exp_s);
    $display("mismatch %s: addr %h/%h status %0d/%0d at %0t", what, got_a, exp_a,
             got_s, exp_s, $realtime);
    err_cnt++;
  endtask

  function automatic void push_blk(int unsigned cls, logic [15:0] a);
    int unsigned g;
    g = 32'(a >> GB);
    next_link[g] = class_head[cls];
    class_head[cls] = {1'b1, g[IDX_W-1:0]};
  endfunction

  function automatic bit page_take(int unsigned bytes, output logic [15:0] a);
    if (cur_off > PAGE_BYTES_D || bytes > PAGE_BYTES_D - cur_off) return 1'b0;
    a = 16'((cur_page * PAGE_BYTES_D + cur_off) & 32'hFFFF);
    cur_off += bytes;
    return 1'b1;
  endfunction

  function automatic alloc_rsp_t predict_rsp(logic kind, logic [15:0] size,
                                             logic [15:0] baddr);
    alloc_rsp_t  r;
    int unsigned cls;
    int unsigned g;
    int unsigned s;
    logic [15:0] a;
    r.addr = '0;
    r.status = ST_OK;
    if (size > SMALL_LIMIT_D) begin
      r.status = ST_LARGE;
      return r;
    end
    cls = (int'(size) + (1 << GB) - 1) >> GB;
    if (cls == 0) cls = 1;
    if (cls >= CLASS_COUNT_D) begin
      r.status = ST_LARGE;
      return r;
    end
    if (kind == REQ_FREE) begin
      push_blk(cls, baddr);
      return r;
    end
    if (class_head[cls][LINK_W-1]) begin
      g = 32'(class_head[cls][IDX_W-1:0]);
      class_head[cls] = next_link[g];
      r.addr = 16'(g << GB);
      return r;
    end
    if (page_take(cls << GB, a)) begin
      r.addr = a;
      return r;
    end
    s = cls - 1;
    while (s >= 1) begin
      if (page_take(s << GB, a)) push_blk(s, a);
      else s--;
    end
    if (cur_page + 1 < PAGE_COUNT_D) begin
      cur_page++;
      cur_off = 0;
      if (page_take(cls << GB, a)) begin
        r.addr = a;
        return r;
      end
    end
    r.status = ST_OOM;
    return r;
  endfunction

  task automatic send_req(logic kind, logic [15:0] size, logic [15:0] baddr,
                          bit typed, logic [15:0] ea, status_t es, bit burst);
    int         gap;
    alloc_rsp_t r;
    gap = burst ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid         <= 1'b1;
    req_if.req_type      <= kind;
    req_if.req_size      <= size;
    req_if.block_address <= baddr;
    do @(posedge clk); while (!req_if.ready);
    r = predict_rsp(kind, size, baddr);
    if (typed && (r.addr !== ea || r.status !== es))
      report("table", r.addr, ea, r.status, es);
    rsp_q.push_back(typed ? alloc_rsp_t'{ea, es} : r);
    if (kind == REQ_ALLOC && r.status == ST_OK)
      live_q.push_back('{r.addr, size});
  endtask

  // receiver
  initial begin
    int         gap;
    alloc_rsp_t e;
    rsp_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!rsp_if.valid);
      if (rsp_q.size() == 0) begin
        report("unexpected item", rsp_if.result_address, 16'h0, rsp_if.status, 0);
      end else begin
        e = rsp_q.pop_front();
        if (rsp_if.result_address !== e.addr || rsp_if.status !== e.status)
          report("result", rsp_if.result_address, e.addr, rsp_if.status, e.status);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= IDLE_MAX) begin
        $display("size_class_block_allocator_tb: FAIL");
        $finish;
      end
    end
  end

  stim_row_t dir_tab [] = '{
    '{REQ_ALLOC, 16'd0,     16'h0000, 1, 16'h0000, ST_OK},
    '{REQ_ALLOC, 16'd128,   16'hFFFF, 1, 16'h0008, ST_OK},
    '{REQ_ALLOC, 16'd129,   16'h0000, 1, 16'h0000, ST_LARGE},
    '{REQ_ALLOC, 16'hFFFF,  16'h0000, 1, 16'h0000, ST_LARGE},
    '{REQ_FREE,  16'd129,   16'h0000, 1, 16'h0000, ST_LARGE},
    '{REQ_FREE,  16'd0,     16'hFFFF, 1, 16'h0000, ST_OK},
    '{REQ_ALLOC, 16'd1,     16'h0000, 1, 16'hFFF8, ST_OK},
    '{REQ_FREE,  16'hFFFF,  16'h1234, 1, 16'h0000, ST_LARGE},
    '{REQ_ALLOC, 16'd8,     16'h0000, 1, 16'h0088, ST_OK},
    '{REQ_FREE,  16'd128,   16'h0008, 1, 16'h0000, ST_OK},
    '{REQ_ALLOC, 16'd121,   16'h0000, 1, 16'h0008, ST_OK},
    '{REQ_ALLOC, 16'd64,    16'h0000, 0, 16'h0000, ST_OK},
    '{REQ_FREE,  16'd64,    16'h0ABC, 0, 16'h0000, ST_OK},
    '{REQ_FREE,  16'd64,    16'h0ABC, 0, 16'h0000, ST_OK},
    '{REQ_ALLOC, 16'd57,    16'h0000, 0, 16'h0000, ST_OK},
    '{REQ_ALLOC, 16'd64,    16'h0000, 0, 16'h0000, ST_OK},
    '{REQ_FREE,  16'd7,     16'h5550, 0, 16'h0000, ST_OK},
    '{REQ_ALLOC, 16'd16,    16'h0000, 0, 16'h0000, ST_OK},
    '{REQ_ALLOC, 16'd100,   16'h0000, 0, 16'h0000, ST_OK},
    '{REQ_ALLOC, 16'd120,   16'h0000, 0, 16'h0000, ST_OK},
    '{REQ_ALLOC, 16'd9,     16'h0000, 0, 16'h0000, ST_OK}
  };

  initial begin
    int          i;
    int          k;
    bit          burst;
    logic        kind;
    logic [15:0] size;
    logic [15:0] baddr;
    err_cnt   = 0;
    hold_req  = 1'b0;
    stim_done = 1'b0;
    cur_page  = 0;
    cur_off   = 0;
    foreach (class_head[c]) class_head[c] = '0;
    rst_n                = 1'b0;
    req_if.valid         = 1'b0;
    req_if.req_type      = REQ_ALLOC;
    req_if.req_size      = '0;
    req_if.block_address = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[j])
      send_req(dir_tab[j].kind, dir_tab[j].size, dir_tab[j].baddr, dir_tab[j].typed,
               dir_tab[j].exp_addr, dir_tab[j].exp_status, 1'b0);

    burst = 1'b0;
    for (i = 0; i < N_RANDOM; i++) begin
      if (i % 50 == 0) burst = ($urandom_range(0, 3) == 0);
      if (i == 300) hold_req = 1'b1;
      baddr = 16'($urandom);
      if ($urandom_range(0, 9) == 0) begin
        kind = 1'($urandom_range(0, 1));
        size = ($urandom_range(0, 1) == 1) ? 16'($urandom) : 16'($urandom_range(129, 300));
      end else if ($urandom_range(0, 9) < 4 && live_q.size() > 0) begin
        kind = REQ_FREE;
        k = $urandom_range(0, live_q.size() - 1);
        baddr = live_q[k].addr;
        size = live_q[k].size;
        if ($urandom_range(0, 19) != 0) live_q.delete(k);
      end else if ($urandom_range(0, 19) == 0) begin
        kind = REQ_FREE;
        size = 16'($urandom_range(0, SMALL_LIMIT_D));
      end else begin
        kind = REQ_ALLOC;
        size = 16'($urandom_range(0, SMALL_LIMIT_D));
      end
      send_req(kind, size, baddr, 1'b0, 16'h0, ST_OK, burst);
    end

    // drive the heap toward and past exhaustion
    for (i = 0; i < N_FILL; i++) begin
      if (i % 40 == 0) burst = ($urandom_range(0, 2) == 0);
      size = 16'($urandom_range(SMALL_LIMIT_D - 40, SMALL_LIMIT_D));
      kind = ($urandom_range(0, 9) == 0 && live_q.size() > 0) ? REQ_FREE : REQ_ALLOC;
      baddr = 16'($urandom);
      if (kind == REQ_FREE) begin
        k = $urandom_range(0, live_q.size() - 1);
        baddr = live_q[k].addr;
        size = live_q[k].size;
        live_q.delete(k);
      end
      send_req(kind, size, baddr, 1'b0, 16'h0, ST_OK, burst);
    end
    req_if.valid <= 1'b0;
    stim_done = 1'b1;

    while (rsp_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("size_class_block_allocator_tb: PASS");
    end else begin
      $display("size_class_block_allocator_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/scba_pkg.sv
design/scba_if.sv
design/scba_ram.sv
design/size_class_block_allocator.sv
tb/sv/size_class_block_allocator_tb.sv
